FILE: sv/fvr_pkg.sv
// Package for the four-channel volume fade ramp.
// Request codes, fade kinds, fixed constants, attenuation curve and the
// divider handshake types. No dependencies.
package fvr_pkg;

  localparam int unsigned CHANNELS_DEF  = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned OUT_CH        = 4;
  localparam int unsigned VOL_W         = 8;
  localparam int unsigned ATTEN_W       = 11;
  localparam int unsigned TIME_W        = 16;
  localparam int unsigned FRAMES_W      = 16;
  localparam int unsigned DIV_W         = 16;
  localparam int unsigned LEFT_W        = 17;

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_PRESET   = 3'd1;
  localparam logic [2:0] REQ_EXPLICIT = 3'd2;
  localparam logic [2:0] REQ_SET      = 3'd3;
  localparam logic [2:0] REQ_SET_LIM  = 3'd4;

  localparam logic [1:0] KIND_LIMIT   = 2'd1;
  localparam logic [1:0] KIND_SILENCE = 2'd2;

  localparam logic signed [VOL_W-1:0] VOL_MIN          = -8'sd127;
  localparam logic signed [VOL_W-1:0] VOL_KEEP_PRESET  = 8'sd1;
  localparam logic signed [VOL_W-1:0] VOL_KEEP_EXPL    = -8'sd1;
  localparam logic signed [VOL_W-1:0] LIMIT_KNEE       = -8'sd20;
  localparam logic signed [VOL_W-1:0] LIMIT_OFFSET     = 8'sd20;

  localparam logic [DIV_W-1:0] CS_PER_SEC   = 16'd100;
  localparam logic [DIV_W-1:0] FRAME_RATE   = 16'd30;
  localparam logic [DIV_W-1:0] FRAC_MUL     = 16'd6;

  // reciprocals: 2^23/100 and 2^11/10 rounded up, exact over the input ranges
  localparam logic [16:0]      SEC_RECIP    = 17'd83887;
  localparam int unsigned      SEC_SHIFT    = 23;
  localparam logic [7:0]       TENTH_RECIP  = 8'd205;
  localparam int unsigned      TENTH_SHIFT  = 11;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
  } div_rsp_t;

  function automatic logic signed [VOL_W-1:0] clamp_vol(input logic signed [VOL_W-1:0] v);
    logic signed [VOL_W-1:0] r;
    r = v;
    if (v < VOL_MIN) r = VOL_MIN;
    if (v > 8'sd0) r = 8'sd0;
    return r;
  endfunction

  function automatic logic signed [ATTEN_W-1:0] curve(input logic [6:0] idx);
    int i;
    int a;
    i = int'(idx);
    if (i <= 32) a = -2 * i;
    else if (i <= 64) a = -64 - 6 * (i - 32);
    else if (i <= 96) a = -256 - 8 * (i - 64);
    else if (i <= 126) a = -512 - 16 * (i - 96);
    else a = -999;
    return ATTEN_W'(a);
  endfunction

endpackage

FILE: sv/fvr_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Uses fvr_pkg for the request/response types.
module fvr_div #(
  parameter int unsigned DW = fvr_pkg::FRAC_BITS_DEF + 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fvr_pkg::div_req_t req_i,
  input  logic [DW-1:0]     dividend_i,
  output fvr_pkg::div_rsp_t rsp_o,
  output logic [DW-1:0]     quo_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic                      run_q;
  logic                      done_q;
  logic [CW-1:0]             cnt_q;
  logic [DW-1:0]             quo_q;
  logic [fvr_pkg::DIV_W-1:0] rem_q;
  logic [fvr_pkg::DIV_W-1:0] dvs_q;
  logic [fvr_pkg::DIV_W:0]   shifted;
  logic [fvr_pkg::DIV_W:0]   trial;
  logic                      fits;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = ~trial[fvr_pkg::DIV_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= CW'(DW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (run_q) begin
      rem_q <= fits ? trial[fvr_pkg::DIV_W-1:0] : shifted[fvr_pkg::DIV_W-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

FILE: sv/fvr_atten.sv
// Level to attenuation mapping through the 128-entry curve.
// Uses fvr_pkg::curve.
module fvr_atten #(
  parameter int unsigned FRAC_BITS = fvr_pkg::FRAC_BITS_DEF
) (
  input  logic signed [FRAC_BITS+7:0]           level_i,
  output logic signed [fvr_pkg::ATTEN_W-1:0]    atten_o
);

  logic [FRAC_BITS+7:0] mag;

  // level is kept within -127..0, so the negation never overflows
  assign mag     = -level_i;
  assign atten_o = fvr_pkg::curve(mag[FRAC_BITS +: 7]);

endmodule

FILE: sv/four_channel_volume_fade_ramp.sv
// Top level of the four-channel volume fade ramp: sequencer, channel state,
// output register. Uses fvr_pkg, fvr_div and fvr_atten.
//
// One request word is taken at a time; in_ready_o is high only while the
// sequencer is idle, and a result word may still sit in the output register
// while the next request is taken. A tick walks the channels one per cycle.
// The fade step comes from one restoring divider that yields one quotient
// bit per cycle. A preset fade first turns its time into frames by
// reciprocal multiplication in the states ST_PDIV, ST_PWQ and ST_PWR.
// Every request waits in ST_FIN for the output register to empty or be
// read. Levels are signed fixed point with FRAC_BITS fraction bits.
module four_channel_volume_fade_ramp #(
  parameter int unsigned CHANNELS  = fvr_pkg::CHANNELS_DEF,
  parameter int unsigned FRAC_BITS = fvr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          req_type_i,
  input  logic [1:0]                          slot_i,
  input  logic [1:0]                          fade_kind_i,
  input  logic [fvr_pkg::TIME_W-1:0]          time_cs_i,
  input  logic signed [fvr_pkg::VOL_W-1:0]    first_volume_i,
  input  logic signed [fvr_pkg::VOL_W-1:0]    start_volume_i,
  input  logic signed [fvr_pkg::VOL_W-1:0]    end_volume_i,
  input  logic [fvr_pkg::FRAMES_W-1:0]        frame_count_i,
  input  logic signed [fvr_pkg::VOL_W-1:0]    new_volume_i,
  input  logic signed [fvr_pkg::VOL_W-1:0]    max_volume_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                busy_res_o,
  output logic signed [fvr_pkg::ATTEN_W-1:0]  atten_0_o,
  output logic signed [fvr_pkg::ATTEN_W-1:0]  atten_1_o,
  output logic signed [fvr_pkg::ATTEN_W-1:0]  atten_2_o,
  output logic signed [fvr_pkg::ATTEN_W-1:0]  atten_3_o,
  output logic [fvr_pkg::OUT_CH-1:0]          changed_mask_o,
  output logic [fvr_pkg::OUT_CH-1:0]          stop_mask_o
);

  localparam int unsigned LW = FRAC_BITS + 8;
  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned OC = fvr_pkg::OUT_CH;
  localparam int unsigned AW = fvr_pkg::ATTEN_W;
  localparam int unsigned DV = fvr_pkg::DIV_W;
  localparam int unsigned VW = fvr_pkg::VOL_W;
  localparam int unsigned FL = fvr_pkg::LEFT_W;
  localparam logic signed [LW-1:0] LEVEL_MIN = {8'h81, {FRAC_BITS{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_TICK, ST_SET, ST_PDIV, ST_PWQ, ST_PWR, ST_EXPL, ST_STEP, ST_STEPW, ST_FIN
  } state_e;

  function automatic logic signed [LW-1:0] scale_f(input logic signed [VW-1:0] v);
    return {v, {FRAC_BITS{1'b0}}};
  endfunction

  state_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;

  logic signed [LW-1:0] level_q  [CHANNELS];
  logic signed [LW-1:0] level_d  [CHANNELS];
  logic signed [LW-1:0] target_q [CHANNELS];
  logic signed [LW-1:0] target_d [CHANNELS];
  logic signed [LW-1:0] step_q   [CHANNELS];
  logic signed [LW-1:0] step_d   [CHANNELS];
  logic signed [FL-1:0] left_q   [CHANNELS];
  logic signed [FL-1:0] left_d   [CHANNELS];
  logic [1:0]           mode_q   [CHANNELS];
  logic [1:0]           mode_d   [CHANNELS];
  logic signed [VW-1:0] limit_q  [CHANNELS];
  logic signed [VW-1:0] limit_d  [CHANNELS];

  logic          busy_q, busy_d;
  logic [OC-1:0] changed_q, changed_d;
  logic [OC-1:0] stop_q, stop_d;

  // latched request word
  logic [2:0]                   req_q;
  logic [1:0]                   kind_q;
  logic [fvr_pkg::TIME_W-1:0]   time_q;
  logic signed [VW-1:0]         firstv_q;
  logic signed [VW-1:0]         startv_q;
  logic signed [VW-1:0]         endv_q;
  logic [fvr_pkg::FRAMES_W-1:0] frames_q;
  logic signed [VW-1:0]         newv_q;
  logic signed [VW-1:0]         maxv_q;
  logic                         latch;

  logic [9:0]    secs_q, secs_d;
  logic [9:0]    pfrac_q, pfrac_d;
  logic [DV-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d;

  logic [fvr_pkg::TIME_W+16:0] sec_prod;
  logic [6:0]                  sec_rem;
  logic [17:0]                 tenth_prod;

  fvr_pkg::div_req_t div_req;
  fvr_pkg::div_rsp_t div_rsp;
  logic [LW-1:0]     div_dividend;
  logic [LW-1:0]     div_quo;

  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic                 busy_res_q;
  logic [OC-1:0]        changed_res_q;
  logic [OC-1:0]        stop_res_q;
  logic signed [AW-1:0] atten_w [OC];
  logic signed [AW-1:0] atten_q [OC];

  logic signed [LW-1:0] cur_level;
  logic signed [LW-1:0] cur_target;
  logic signed [LW:0]   tick_sum;
  logic signed [FL-1:0] left_dec;
  logic signed [LW-1:0] diff;
  logic [DV-1:0]        cnt_sum;
  logic [DV-1:0]        cnt_new;

  assign cur_level  = level_q[idx_q];
  assign cur_target = target_q[idx_q];
  assign tick_sum   = (LW+1)'(cur_level) - (LW+1)'(step_q[idx_q]);
  assign left_dec   = left_q[idx_q] - FL'(1);
  assign diff       = cur_level - cur_target;
  assign sec_prod   = time_q * fvr_pkg::SEC_RECIP;
  assign sec_rem    = 7'(time_q - secs_q * fvr_pkg::CS_PER_SEC);
  assign tenth_prod = pfrac_q * fvr_pkg::TENTH_RECIP;
  assign cnt_sum    = DV'(secs_q * fvr_pkg::FRAME_RATE)
                    + DV'(tenth_prod >> fvr_pkg::TENTH_SHIFT);
  assign cnt_new    = ((cnt_sum >> 1) == '0) ? DV'(1) : (cnt_sum >> 1);

  assign in_ready_o = (state_q == ST_IDLE);

  fvr_div #(.DW(LW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .rsp_o      (div_rsp),
    .quo_o      (div_quo)
  );

  for (genvar k = 0; k < OC; k++) begin : g_atten
    if (k < CHANNELS) begin : g_on
      fvr_atten #(.FRAC_BITS(FRAC_BITS)) u_atten (
        .level_i (level_q[k]),
        .atten_o (atten_w[k])
      );
    end else begin : g_off
      assign atten_w[k] = '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    level_d      = level_q;
    target_d     = target_q;
    step_d       = step_q;
    left_d       = left_q;
    mode_d       = mode_q;
    limit_d      = limit_q;
    busy_d       = busy_q;
    changed_d    = changed_q;
    stop_d       = stop_q;
    secs_d       = secs_q;
    pfrac_d      = pfrac_q;
    cnt_d        = cnt_q;
    neg_d        = neg_q;
    latch        = 1'b0;
    out_load     = 1'b0;
    div_req      = '0;
    div_dividend = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          latch     = 1'b1;
          busy_d    = 1'b0;
          changed_d = '0;
          stop_d    = '0;
          idx_d     = IW'(slot_i);
          if (req_type_i == fvr_pkg::REQ_TICK) begin
            idx_d   = '0;
            state_d = ST_TICK;
          end else if (req_type_i <= fvr_pkg::REQ_SET_LIM && 32'(slot_i) < CHANNELS) begin
            case (req_type_i)
              fvr_pkg::REQ_PRESET:   state_d = ST_PDIV;
              fvr_pkg::REQ_EXPLICIT: state_d = ST_EXPL;
              default:               state_d = ST_SET;
            endcase
          end else begin
            state_d = ST_FIN;
          end
        end
      end

      ST_TICK: begin
        if (mode_q[idx_q] != 2'd0) begin
          left_d[idx_q] = left_dec;
          if (left_dec < 0) begin
            level_d[idx_q] = cur_target;
            mode_d[idx_q]  = 2'd0;
            if (cur_target == LEVEL_MIN) stop_d = stop_q | (OC'(1) << idx_q);
          end else begin
            if (tick_sum < (LW+1)'(LEVEL_MIN)) level_d[idx_q] = LEVEL_MIN;
            else if (tick_sum > 0) level_d[idx_q] = '0;
            else level_d[idx_q] = tick_sum[LW-1:0];
            busy_d = 1'b1;
          end
          changed_d = changed_d | (OC'(1) << idx_q);
        end
        if (idx_q == IW'(CHANNELS - 1)) state_d = ST_FIN;
        else idx_d = idx_q + 1'b1;
      end

      ST_SET: begin
        if (req_q == fvr_pkg::REQ_SET_LIM) begin
          limit_d[idx_q] = (maxv_q < fvr_pkg::LIMIT_KNEE) ? maxv_q + fvr_pkg::LIMIT_OFFSET
                                                          : '0;
        end
        level_d[idx_q] = scale_f(fvr_pkg::clamp_vol(newv_q));
        changed_d      = changed_q | (OC'(1) << idx_q);
        state_d        = ST_FIN;
      end

      // seconds, then six tenths of the leftover hundredths
      ST_PDIV: begin
        secs_d  = 10'(sec_prod >> fvr_pkg::SEC_SHIFT);
        state_d = ST_PWQ;
      end

      ST_PWQ: begin
        pfrac_d = 10'(sec_rem * fvr_pkg::FRAC_MUL);
        state_d = ST_PWR;
      end

      ST_PWR: begin
        left_d[idx_q] = FL'(cnt_new);
        cnt_d         = cnt_new;
        if (firstv_q != fvr_pkg::VOL_KEEP_PRESET) begin
          level_d[idx_q] = scale_f(fvr_pkg::clamp_vol(firstv_q));
          changed_d      = changed_q | (OC'(1) << idx_q);
        end
        if (kind_q == fvr_pkg::KIND_LIMIT) target_d[idx_q] = scale_f(limit_q[idx_q]);
        else if (kind_q == fvr_pkg::KIND_SILENCE) target_d[idx_q] = LEVEL_MIN;
        mode_d[idx_q] = kind_q;
        state_d       = ST_STEP;
      end

      ST_EXPL: begin
        if (startv_q != fvr_pkg::VOL_KEEP_EXPL) begin
          level_d[idx_q] = scale_f(fvr_pkg::clamp_vol(startv_q));
        end
        changed_d       = changed_q | (OC'(1) << idx_q);
        target_d[idx_q] = scale_f(fvr_pkg::clamp_vol(endv_q));
        left_d[idx_q]   = FL'(frames_q);
        mode_d[idx_q]   = 2'd1;
        cnt_d           = DV'(frames_q);
        state_d         = (frames_q != '0) ? ST_STEP : ST_FIN;
      end

      ST_STEP: begin
        neg_d           = diff[LW-1];
        div_req.start   = 1'b1;
        div_req.divisor = cnt_q;
        div_dividend    = diff[LW-1] ? -diff : diff;
        state_d         = ST_STEPW;
      end

      ST_STEPW: begin
        if (div_rsp.done) begin
          step_d[idx_q] = neg_q ? -div_quo : div_quo;
          state_d       = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      busy_q      <= 1'b0;
      changed_q   <= '0;
      stop_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        level_q[i]  <= '0;
        target_q[i] <= '0;
        step_q[i]   <= '0;
        left_q[i]   <= '0;
        mode_q[i]   <= '0;
        limit_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      busy_q      <= busy_d;
      changed_q   <= changed_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
      level_q     <= level_d;
      target_q    <= target_d;
      step_q      <= step_d;
      left_q      <= left_d;
      mode_q      <= mode_d;
      limit_q     <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    secs_q  <= secs_d;
    pfrac_q <= pfrac_d;
    cnt_q   <= cnt_d;
    neg_q   <= neg_d;
    if (latch) begin
      req_q    <= req_type_i;
      kind_q   <= fade_kind_i;
      time_q   <= time_cs_i;
      firstv_q <= first_volume_i;
      startv_q <= start_volume_i;
      endv_q   <= end_volume_i;
      frames_q <= frame_count_i;
      newv_q   <= new_volume_i;
      maxv_q   <= max_volume_i;
    end
    if (out_load) begin
      busy_res_q    <= busy_q;
      changed_res_q <= changed_q;
      stop_res_q    <= stop_q;
      atten_q       <= atten_w;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign busy_res_o     = busy_res_q;
  assign changed_mask_o = changed_res_q;
  assign stop_mask_o    = stop_res_q;
  assign atten_0_o      = atten_q[0];
  assign atten_1_o      = atten_q[1];
  assign atten_2_o      = atten_q[2];
  assign atten_3_o      = atten_q[3];

endmodule
